[src/mhwa_pkg.sv]
// ----------------------------------------------------------------------------
// mhwa_pkg
// Shared types and constants for the multichannel history window average.
// ----------------------------------------------------------------------------
package mhwa_pkg;

	// defaults for the top level parameters
	localparam int CHANNELS_DEF = 4;
	localparam int DEPTH_DEF    = 256;

	// field widths
	localparam int SAMPLE_W      = 16;
	localparam int SAMPLE_FIELDS = 4;
	localparam int CH_W          = 2;
	localparam int WIN_W         = 9;

	// stream widths
	localparam int IN_TDATA_W  = 80;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 32;

	// window sum: 511 samples of 16 bits, plus sign headroom
	localparam int SUM_W  = 26;
	localparam int DCNT_W = $clog2(SUM_W + 1);

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		OP_PUSH  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SUM,
		BK_DIV,
		BK_FIN
	} bk_state_t;

	// classified command as it travels through the queue
	typedef struct packed {
		op_t                                    op;
		logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] sample;
		logic [CH_W-1:0]                        channel;
		logic [WIN_W-1:0]                       window;   // already clamped to depth
		logic                                   ch_ok;    // channel exists
	} cmd_t;

endpackage

[src/mhwa_front.sv]
// ----------------------------------------------------------------------------
// mhwa_front
// Input stage: takes beats, unpacks and classifies them into commands.
// ----------------------------------------------------------------------------
module mhwa_front
	import mhwa_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int DEPTH    = DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,
	input  logic [IN_TUSER_W-1:0] s_tuser,
	output logic                  q_valid,
	input  logic                  q_ready,
	output cmd_t                  q_cmd
);

	cmd_t cmd_in;
	cmd_t cmd_s1;
	logic v_s1;

	// unpack and classify the incoming beat
	always_comb begin
		cmd_in.op = op_t'(s_tuser[0]);
		for (int i = 0; i < SAMPLE_FIELDS; i++) begin
			cmd_in.sample[i] = s_tdata[i*SAMPLE_W +: SAMPLE_W];
		end
		cmd_in.channel = s_tuser[CH_W:1];
		cmd_in.window  = s_tdata[SAMPLE_FIELDS*SAMPLE_W +: WIN_W];
		if (32'(cmd_in.window) > DEPTH) begin
			cmd_in.window = WIN_W'(DEPTH);
		end
		cmd_in.ch_ok = (32'(cmd_in.channel) < CHANNELS);
	end

	assign s_tready = !v_s1 || q_ready;
	assign q_valid  = v_s1;
	assign q_cmd    = cmd_s1;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1 <= 1'b1;
		end else if (q_ready) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule

[src/mhwa_fifo.sv]
// ----------------------------------------------------------------------------
// mhwa_fifo
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module mhwa_fifo
	import mhwa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_pop,
	output cmd_t out_cmd
);

	cmd_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	logic              pop;

	assign in_ready  = (cnt_q != QCNT_W'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_cmd   = ent_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_pop && out_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

endmodule

[src/mhwa_back.sv]
// ----------------------------------------------------------------------------
// mhwa_back
// Execution side: sample memories, write pointer, window sum, serial divider
// and the result register.
// ----------------------------------------------------------------------------
module mhwa_back
	import mhwa_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int DEPTH    = DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  cmd_t                q_cmd,
	output logic                q_pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [SAMPLE_W-1:0] m_average,
	output logic [WIN_W-1:0]    m_samples_used
);

	// only channels with an input field ever hold nonzero data or get queried
	localparam int NUM_MEM = (CHANNELS < SAMPLE_FIELDS) ? CHANNELS : SAMPLE_FIELDS;
	localparam int WP_W    = $clog2(DEPTH);

	bk_state_t state_q;
	bk_state_t state_d;

	logic [WP_W-1:0]               wp_q;
	logic                          wrapped_q;
	logic [WP_W-1:0]               addr_q;
	logic [WIN_W-1:0]              n_q;
	logic [WIN_W-1:0]              iss_q;
	logic [CH_W-1:0]               ch_q;
	logic                          rd_v_s1;
	logic [SAMPLE_W-1:0]           rdata_s1 [NUM_MEM];
	logic signed [SUM_W-1:0]       acc_q;
	logic [SUM_W-1:0]              dvd_q;
	logic [WIN_W-1:0]              rem_q;
	logic [DCNT_W-1:0]             dcnt_q;
	logic                          neg_q;
	logic                          out_v_q;

	logic                          wr_en;
	logic                          issue;
	logic                          load;
	logic                          sum_done;
	logic [31:0]                   avail;
	logic [WIN_W-1:0]              n_calc;
	logic [SAMPLE_W-1:0]           sel;
	logic [WIN_W:0]                trial;
	logic                          qbit;
	logic [SUM_W-1:0]              quo;

	// window length available for the query at the head of the queue
	always_comb begin
		avail  = wrapped_q ? 32'(DEPTH) : 32'(wp_q);
		n_calc = q_cmd.window;
		if (32'(n_calc) > avail) begin
			n_calc = WIN_W'(avail);
		end
		if (!q_cmd.ch_ok) begin
			n_calc = '0;
		end
	end

	assign sum_done = (iss_q == '0) && !rd_v_s1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid && q_cmd.op == OP_QUERY) begin
					state_d = (n_calc == '0) ? BK_FIN : BK_SUM;
				end
			end
			BK_SUM: begin
				if (sum_done) state_d = BK_DIV;
			end
			BK_DIV: begin
				if (dcnt_q == DCNT_W'(SUM_W - 1)) state_d = BK_FIN;
			end
			BK_FIN: begin
				if (!out_v_q || m_tready) state_d = BK_IDLE;
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		q_pop = 1'b0;
		issue = 1'b0;
		load  = 1'b0;
		unique case (state_q)
			BK_IDLE: q_pop = q_valid;
			BK_SUM:  issue = (iss_q != '0);
			BK_DIV:  ;
			BK_FIN:  load = !out_v_q || m_tready;
			default: ;
		endcase
	end

	assign wr_en = q_pop && (q_cmd.op == OP_PUSH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// write pointer and wrap flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q      <= '0;
			wrapped_q <= 1'b0;
		end else if (wr_en) begin
			if (wp_q == WP_W'(DEPTH - 1)) begin
				wp_q      <= '0;
				wrapped_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	// one sample memory per channel, registered read
	for (genvar c = 0; c < NUM_MEM; c++) begin : g_mem
		logic [SAMPLE_W-1:0] mem [DEPTH];
		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wp_q] <= q_cmd.sample[c];
			end
			rdata_s1[c] <= mem[addr_q];
		end
	end

	// channel select on the read data
	always_comb begin
		sel = '0;
		for (int c = 0; c < NUM_MEM; c++) begin
			if (ch_q == CH_W'(c)) sel = rdata_s1[c];
		end
	end

	// restoring divider step on the sum magnitude
	always_comb begin
		trial = {rem_q, dvd_q[SUM_W-1]};
		qbit  = (trial >= {1'b0, n_q});
		quo   = neg_q ? (~dvd_q + 1'b1) : dvd_q;
	end

	// read valid tracks the memory latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
		end
	end

	// query datapath: address walk, accumulation, division
	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.op == OP_QUERY) begin
			n_q    <= n_calc;
			iss_q  <= n_calc;
			ch_q   <= q_cmd.channel;
			addr_q <= (wp_q == '0) ? WP_W'(DEPTH - 1) : wp_q - 1'b1;
			acc_q  <= '0;
			dvd_q  <= '0;
			neg_q  <= 1'b0;
		end
		if (issue) begin
			iss_q  <= iss_q - 1'b1;
			addr_q <= (addr_q == '0) ? WP_W'(DEPTH - 1) : addr_q - 1'b1;
		end
		if (rd_v_s1) begin
			acc_q <= acc_q + {{(SUM_W-SAMPLE_W){sel[SAMPLE_W-1]}}, sel};
		end
		if (state_q == BK_SUM && sum_done) begin
			neg_q  <= acc_q[SUM_W-1];
			dvd_q  <= acc_q[SUM_W-1] ? (~acc_q + 1'b1) : acc_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (state_q == BK_DIV) begin
			rem_q  <= qbit ? WIN_W'(trial - {1'b0, n_q}) : trial[WIN_W-1:0];
			dvd_q  <= {dvd_q[SUM_W-2:0], qbit};
			dcnt_q <= dcnt_q + 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_average      <= quo[SAMPLE_W-1:0];
			m_samples_used <= n_q;
		end
	end

	assign m_tvalid = out_v_q;

	// checks
	a_used_le_depth: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (32'(m_samples_used) <= DEPTH))
		else $error("result count exceeds depth");

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wp_q) < DEPTH)
		else $error("write pointer out of range");

	a_sum_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SUM) |-> (n_q != '0))
		else $error("summing an empty window");

	a_read_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> (state_q == BK_SUM))
		else $error("read data returned outside the sum phase");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_DIV) |-> (rem_q < n_q))
		else $error("divider remainder not below divisor");

endmodule

[src/multichannel_history_window_average.sv]
// ----------------------------------------------------------------------------
// multichannel_history_window_average
// Circular sample history per channel with windowed mean queries.
// ----------------------------------------------------------------------------
//
//  channel   dir  signals                    beat contents
//  s_*       in   tvalid tready tdata tuser  push samples or query request
//  m_*       out  tvalid tready tdata        query result
//
//  a push is written to the back end memories when it is popped from the queue head
//  a query runs the one-sample-a-cycle memory walk over its n samples used,
//  then the bit-serial divider over the SUM_W-bit sum (SUM_W = 26)
//  reset clears the write pointer, wrap flag, queue and result register
//  a waiting result stalls the back end; the front register and the
//  two-entry command queue take up to three more beats before s_tready drops
//
module multichannel_history_window_average
	import mhwa_pkg::*;
#(
	parameter int CHANNELS = CHANNELS_DEF,
	parameter int DEPTH    = DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // sample_0, sample_1, sample_2, sample_3, window
	input  logic [IN_TUSER_W-1:0]  s_tuser,   // op, channel
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // average, samples_used
);

	logic                fr_valid;
	logic                fr_ready;
	cmd_t                fr_cmd;
	logic                bk_valid;
	logic                bk_pop;
	cmd_t                bk_cmd;
	logic [SAMPLE_W-1:0] average;
	logic [WIN_W-1:0]    samples_used;

	// beat intake and classification
	mhwa_front #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_valid  (fr_valid),
		.q_ready  (fr_ready),
		.q_cmd    (fr_cmd)
	);

	// command queue
	mhwa_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_cmd    (fr_cmd),
		.out_valid (bk_valid),
		.out_pop   (bk_pop),
		.out_cmd   (bk_cmd)
	);

	// history and averaging engine
	mhwa_back #(
		.CHANNELS (CHANNELS),
		.DEPTH    (DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (bk_valid),
		.q_cmd          (bk_cmd),
		.q_pop          (bk_pop),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_average      (average),
		.m_samples_used (samples_used)
	);

	// result packing
	assign m_tdata = {(OUT_TDATA_W-SAMPLE_W-WIN_W)'(0), samples_used, average};

endmodule

[verif/multichannel_history_window_average_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_history_window_average_test
// Streams push and query beats into the history averager under random
// idle gaps and output stalls. Every query is predicted from a local copy of
// the four channel histories and the shared write pointer, and each output
// beat is compared with the oldest predicted mean and sample count.
// ----------------------------------------------------------------------------
module multichannel_history_window_average_test;
	import mhwa_pkg::*;

	localparam int CHANS      = CHANNELS_DEF;
	localparam int HIST_DEPTH = DEPTH_DEF;
	// longest query: full window walk plus the serial divide, with margin
	localparam int DRAIN_CYCLES = HIST_DEPTH + SUM_W + 60;
	localparam int RANDOM_ITEMS = 700;

	typedef logic [SAMPLE_FIELDS-1:0][SAMPLE_W-1:0] sample_set_t;

	typedef struct {
		logic signed [SAMPLE_W-1:0] average;
		logic [WIN_W-1:0]           samples_used;
	} window_mean_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // sample_0, sample_1, sample_2, sample_3, window
	logic [IN_TUSER_W-1:0]  s_tuser;   // op, channel
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // average, samples_used

	// local copy of the block state
	logic signed [SAMPLE_W-1:0] history [CHANS][HIST_DEPTH];
	int                         wr_ptr;
	bit                         has_wrapped;

	window_mean_t predicted_means[$];
	int           mismatch_count;
	bit           sender_free;
	bit           receiver_free;

	multichannel_history_window_average #(
		.CHANNELS(CHANS),
		.DEPTH(HIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// safety net against a hung handshake
	initial begin
		#40_000_000;
		$display("multichannel_history_window_average_test NOT OK");
		$finish;
	end

	// mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		else if (roll < 85)
			return $urandom_range(1, 3);
		else
			return $urandom_range(5, 40);
	endfunction

	// write one sample set at the pointer and advance it
	function automatic void store_sample_set(sample_set_t samples);
		for (int ch = 0; ch < CHANS; ch++)
			history[ch][wr_ptr] = (ch < SAMPLE_FIELDS) ? samples[ch] : '0;
		wr_ptr++;
		if (wr_ptr >= HIST_DEPTH) begin
			wr_ptr      = 0;
			has_wrapped = 1'b1;
		end
	endfunction

	// mean of the most recent samples of one channel
	function automatic window_mean_t window_mean(logic [CH_W-1:0] ch, logic [WIN_W-1:0] win);
		window_mean_t r;
		int           n;
		int           avail;
		int           slot;
		longint       total;
		avail = has_wrapped ? HIST_DEPTH : wr_ptr;
		n     = win;
		if (n > HIST_DEPTH)
			n = HIST_DEPTH;
		if (n > avail)
			n = avail;
		if (ch >= CHANS)
			n = 0;
		total = 0;
		for (int k = 0; k < n; k++) begin
			slot  = (wr_ptr + HIST_DEPTH - 1 - k) % HIST_DEPTH;
			total += history[ch][slot];
		end
		// longint division truncates toward zero
		r.average      = (n > 0) ? SAMPLE_W'(total / n) : '0;
		r.samples_used = WIN_W'(n);
		return r;
	endfunction

	// drive one beat, wait for acceptance, update the prediction
	task automatic send_beat(input op_t op, input sample_set_t samples,
			input logic [CH_W-1:0] ch, input logic [WIN_W-1:0] win);
		logic [IN_TDATA_W-1:0] beat_data;
		int                    gap;
		beat_data = '0;
		beat_data[SAMPLE_FIELDS*SAMPLE_W-1:0]      = samples;
		beat_data[SAMPLE_FIELDS*SAMPLE_W +: WIN_W] = win;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= beat_data;
		s_tuser  <= {ch, op};
		do @(posedge clk); while (!s_tready);
		if (op == OP_PUSH)
			store_sample_set(samples);
		else
			predicted_means.push_back(window_mean(ch, win));
		gap = sender_free ? 0 : idle_cycles();
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic push_set(input sample_set_t samples);
		send_beat(OP_PUSH, samples, '0, '0);
	endtask

	task automatic query_mean(input logic [CH_W-1:0] ch, input logic [WIN_W-1:0] win);
		send_beat(OP_QUERY, '0, ch, win);
	endtask

	// output ready with random stalls
	initial begin
		int stall_left;
		stall_left = 0;
		m_tready   = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!receiver_free && $urandom_range(0, 2) == 0)
					stall_left = idle_cycles();
			end
		end
	end

	// compare each output beat with the oldest predicted mean
	always @(posedge clk) begin
		window_mean_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (predicted_means.size() == 0) begin
				$error("unexpected result beat: average %0d, samples_used %0d",
					$signed(m_tdata[SAMPLE_W-1:0]), m_tdata[SAMPLE_W +: WIN_W]);
				mismatch_count++;
			end else begin
				want = predicted_means.pop_front();
				if (m_tdata[SAMPLE_W-1:0] !== want.average) begin
					$error("average: expected %0d, got %0d",
						want.average, $signed(m_tdata[SAMPLE_W-1:0]));
					mismatch_count++;
				end
				if (m_tdata[SAMPLE_W +: WIN_W] !== want.samples_used) begin
					$error("samples_used: expected %0d, got %0d",
						want.samples_used, m_tdata[SAMPLE_W +: WIN_W]);
					mismatch_count++;
				end
			end
		end
	end

	// queries before any sample was written
	task automatic test_empty_history();
		query_mean(2'd0, 9'd1);
		query_mean(2'd3, 9'd256);
		query_mean(2'd1, 9'd0);
		query_mean(2'd2, 9'd511);
	endtask

	// full-scale samples, window shrink, clamp and zero window
	task automatic test_extreme_samples();
		push_set({16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF});
		push_set({16'hFFFE, 16'h0001, 16'h8000, 16'h7FFF});
		push_set({16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000});
		for (int ch = 0; ch < SAMPLE_FIELDS; ch++)
			query_mean(CH_W'(ch), 9'd3);
		query_mean(2'd0, 9'd2);
		query_mean(2'd2, 9'd0);
		query_mean(2'd1, 9'd300);
		query_mean(2'd3, 9'd511);
	endtask

	// negative and odd sums round toward zero
	task automatic test_truncation();
		push_set({16'h0003, 16'hFFFE, 16'h0001, 16'hFFFF});
		push_set({16'h0000, 16'h0000, 16'h0000, 16'h0000});
		query_mean(2'd0, 9'd2);
		query_mean(2'd1, 9'd2);
		query_mean(2'd2, 9'd2);
		query_mean(2'd3, 9'd2);
		query_mean(2'd2, 9'd5);
	endtask

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2:       return SAMPLE_W'($urandom_range(0, 6) - 3);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic [WIN_W-1:0] random_window();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return WIN_W'($urandom_range(HIST_DEPTH + 1, 511));
			2:       return WIN_W'(HIST_DEPTH);
			3, 4:    return WIN_W'($urandom_range(1, 8));
			default: return WIN_W'($urandom_range(0, HIST_DEPTH));
		endcase
	endfunction

	// random mix of pushes and queries, through and past the wrap
	task automatic test_random_traffic();
		sample_set_t samples;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// change the idling pattern now and then
			if (i % 64 == 0) begin
				sender_free   = ($urandom_range(0, 3) == 0);
				receiver_free = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 99) < 60) begin
				for (int f = 0; f < SAMPLE_FIELDS; f++)
					samples[f] = random_sample();
				push_set(samples);
			end else begin
				query_mean(CH_W'($urandom_range(0, CHANS - 1)), random_window());
			end
		end
	endtask

	// stimulus and end of run
	initial begin
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		wr_ptr         = 0;
		has_wrapped    = 1'b0;
		mismatch_count = 0;
		sender_free    = 1'b0;
		receiver_free  = 1'b0;
		for (int ch = 0; ch < CHANS; ch++)
			for (int k = 0; k < HIST_DEPTH; k++)
				history[ch][k] = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_history();
		test_extreme_samples();
		test_truncation();
		test_random_traffic();

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (predicted_means.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("multichannel_history_window_average_test OK");
		else
			$display("multichannel_history_window_average_test NOT OK");
		$finish;
	end

endmodule
